// File: sv/mpbd_pkg.sv
// shared types, constants and request frame table for the meter poll and decode block
`default_nettype none
package mpbd_pkg;

	localparam int REQUEST_LENGTH = 16;
	localparam int IDX_W          = $clog2(REQUEST_LENGTH);
	localparam int IDENT_POS      = 13;
	localparam int DATA_POS       = 18;
	localparam int QUEUE_DEPTH    = 4;
	localparam int TOTAL_W        = 28;
	localparam int READING_W      = 21;
	localparam int USED_W         = 32;
	localparam int START_W        = 28;

	localparam logic [7:0] DATA_OFFSET = 8'h33;
	localparam logic [7:0] ID_VOLT     = 8'h06;
	localparam logic [7:0] ID_CURR     = 8'h07;
	localparam logic [7:0] ID_ENERGY   = 8'h08;

	localparam logic [1:0] KIND_REQ    = 2'd0;
	localparam logic [1:0] KIND_VOLT   = 2'd1;
	localparam logic [1:0] KIND_CURR   = 2'd2;
	localparam logic [1:0] KIND_ENERGY = 2'd3;

	localparam logic [1:0] FRAME_ENERGY = 2'd0;
	localparam logic [1:0] FRAME_CURR   = 2'd1;
	localparam logic [1:0] FRAME_VOLT   = 2'd2;

	localparam logic [READING_W-1:0] READING_MAX = {READING_W{1'b1}};

	// one queued job: a request frame to send, or a reading to decode
	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  frame;
		logic [31:0] data;
	} job_t;

	// byte idx of request frame sel
	function automatic logic [7:0] req_byte(input logic [1:0] sel, input logic [IDX_W-1:0] idx);
		logic [7:0] b;
		b = 8'h00;
		case (idx)
			4'd0:  b = 8'h68;
			4'd1:  b = 8'h50;
			4'd2:  b = 8'h00;
			4'd3:  b = 8'h01;
			4'd4:  b = 8'h07;
			4'd5:  b = 8'h01;
			4'd6:  b = 8'h16;
			4'd7:  b = 8'h68;
			4'd8:  b = 8'h11;
			4'd9:  b = 8'h04;
			4'd10: b = 8'h33;
			4'd11: b = (sel == FRAME_ENERGY) ? 8'h33 : 8'h34;
			4'd12: b = (sel == FRAME_ENERGY) ? 8'h34 : (sel == FRAME_CURR) ? 8'h35 : 8'h34;
			4'd13: b = (sel == FRAME_ENERGY) ? 8'h33 : 8'h35;
			4'd14: b = (sel == FRAME_ENERGY) ? 8'h21 : (sel == FRAME_CURR) ? 8'h25 : 8'h24;
			4'd15: b = 8'h16;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

// File: sv/mpbd_front.sv
// front end: accepts requests, tracks the receive frame and queues jobs
`default_nettype none
module mpbd_front import mpbd_pkg::*; #(
	parameter int FRAME_CAPACITY = 24
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       command,
	input  wire logic [7:0] rx_byte,
	input  wire logic       rx_last,
	input  wire logic       q_full,
	output logic            push,
	output job_t            job
);

	localparam int POS_W = $clog2(FRAME_CAPACITY + 1);

	logic [1:0]       phase_q;
	logic [POS_W-1:0] pos_q;
	logic [7:0]       ident_q;
	logic [7:0]       data_q [4];

	logic             accept;
	logic [1:0]       frame_sel;
	logic [7:0]       ident_nx;
	logic [7:0]       data_nx [4];
	logic [POS_W-1:0] pos_nx;
	logic [POS_W-1:0] data_off;
	logic             known;
	logic [1:0]       kind_rx;

	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;
	assign frame_sel = (phase_q == 2'd3) ? FRAME_ENERGY : phase_q;
	assign data_off  = pos_q - POS_W'(DATA_POS);

	always_comb begin
		ident_nx = ident_q;
		data_nx  = data_q;
		pos_nx   = pos_q;
		if (pos_q < POS_W'(FRAME_CAPACITY)) begin
			if (pos_q == POS_W'(IDENT_POS)) begin
				ident_nx = rx_byte;
			end else if (pos_q >= POS_W'(DATA_POS) && pos_q < POS_W'(DATA_POS + 4)) begin
				data_nx[data_off[1:0]] = rx_byte - DATA_OFFSET;
			end
			pos_nx = pos_q + POS_W'(1);
		end
	end

	always_comb begin
		known   = 1'b1;
		kind_rx = KIND_VOLT;
		case (ident_nx)
			ID_VOLT:   kind_rx = KIND_VOLT;
			ID_CURR:   kind_rx = KIND_CURR;
			ID_ENERGY: kind_rx = KIND_ENERGY;
			default:   known   = 1'b0;
		endcase
	end

	assign push = accept && (!command || (rx_last && known));

	always_comb begin
		job.kind  = command ? kind_rx : KIND_REQ;
		job.frame = frame_sel;
		job.data  = command ? {data_nx[3], data_nx[2], data_nx[1], data_nx[0]} : 32'h0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			pos_q   <= '0;
			ident_q <= 8'h00;
			for (int i = 0; i < 4; i++) data_q[i] <= 8'h00;
		end else if (accept) begin
			if (!command) begin
				phase_q <= (frame_sel == FRAME_VOLT) ? FRAME_ENERGY : frame_sel + 2'd1;
			end else begin
				ident_q <= ident_nx;
				data_q  <= data_nx;
				pos_q   <= rx_last ? '0 : pos_nx;
			end
		end
	end

endmodule
`default_nettype wire

// File: sv/mpbd_queue.sv
// short job queue between front and back
`default_nettype none
module mpbd_queue import mpbd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  job_t      push_job,
	output logic      full,
	input  wire logic pop,
	output job_t      head,
	output logic      empty
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			if (pop)  rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			if (push && !pop)      cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push) cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue pop while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule
`default_nettype wire

// File: sv/mpbd_back.sv
// back end: streams request frames and decodes readings into the output register
`default_nettype none
module mpbd_back import mpbd_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [START_W-1:0]   cfg_wdata,
	input  wire logic                 empty,
	input  job_t                      head,
	output logic                      pop,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [1:0]                result_kind,
	output logic [7:0]                tx_byte,
	output logic                      tx_last,
	output logic [READING_W-1:0]      reading,
	output logic signed [USED_W-1:0]  energy_used
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SEND = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_SUM  = 3'd3;
	localparam logic [2:0] ST_DIFF = 3'd4;
	localparam logic [2:0] ST_USED = 3'd5;

	localparam logic signed [33:0] USED_MAX = 34'sd2147483647;
	localparam logic signed [33:0] USED_MIN = -34'sd2147483648;

	logic [2:0]               state_q;
	logic [1:0]               kind_q;
	logic [1:0]               frame_q;
	logic [IDX_W-1:0]         idx_q;
	logic [START_W-1:0]       start_q;
	logic [7:0]               pair_s1 [4];
	logic [TOTAL_W-1:0]       prod_s2 [4];
	logic [TOTAL_W-1:0]       total_s3;
	logic signed [TOTAL_W:0]  diff_s4;

	logic                     out_valid_q;
	logic [1:0]               kind_out_q;
	logic [7:0]               tx_byte_q;
	logic                     tx_last_q;
	logic [READING_W-1:0]     reading_q;
	logic [USED_W-1:0]        used_q;

	logic                     out_free;
	logic                     load;
	logic signed [33:0]       diff_x;
	logic signed [33:0]       used_x;
	logic [USED_W-1:0]        used_sat;
	logic [READING_W-1:0]     reading_sat;

	assign out_free = !out_valid_q || out_ready;
	assign pop      = (state_q == ST_IDLE) && !empty;
	assign load     = out_free && (state_q == ST_SEND || state_q == ST_USED);

	assign diff_x = 34'(diff_s4);
	assign used_x = (diff_x <<< 3) + (diff_x <<< 1) + 34'sd1;

	always_comb begin
		if (used_x > USED_MAX)      used_sat = 32'h7FFF_FFFF;
		else if (used_x < USED_MIN) used_sat = 32'h8000_0000;
		else                        used_sat = used_x[USED_W-1:0];
	end

	assign reading_sat = (total_s3 > TOTAL_W'(READING_MAX)) ? READING_MAX
	                                                         : total_s3[READING_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
		end else if (cfg_we) begin
			start_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						idx_q   <= '0;
						state_q <= (head.kind == KIND_REQ) ? ST_SEND : ST_MUL;
					end
				end
				ST_SEND: begin
					if (out_free) begin
						idx_q <= idx_q + IDX_W'(1);
						if (idx_q == IDX_W'(REQUEST_LENGTH - 1)) state_q <= ST_IDLE;
					end
				end
				ST_MUL:  state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_DIFF;
				ST_DIFF: state_q <= ST_USED;
				ST_USED: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// decode datapath, one step per state
	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q  <= head.kind;
			frame_q <= head.frame;
			for (int i = 0; i < 4; i++) begin
				pair_s1[i] <= 8'(head.data[8*i+4 +: 4] * 4'd10) + 8'(head.data[8*i +: 4]);
			end
		end
		if (state_q == ST_MUL) begin
			prod_s2[3] <= (kind_q == KIND_ENERGY) ? TOTAL_W'(pair_s1[3]) * TOTAL_W'(1000000) : '0;
			prod_s2[2] <= (kind_q != KIND_VOLT) ? TOTAL_W'(pair_s1[2]) * TOTAL_W'(10000) : '0;
			prod_s2[1] <= TOTAL_W'(pair_s1[1]) * TOTAL_W'(100);
			prod_s2[0] <= TOTAL_W'(pair_s1[0]);
		end
		if (state_q == ST_SUM) begin
			total_s3 <= (prod_s2[3] + prod_s2[2]) + (prod_s2[1] + prod_s2[0]);
		end
		if (state_q == ST_DIFF) begin
			diff_s4 <= $signed({1'b0, total_s3}) - $signed({1'b0, start_q});
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (state_q == ST_SEND) begin
				kind_out_q <= KIND_REQ;
				tx_byte_q  <= req_byte(frame_q, idx_q);
				tx_last_q  <= (idx_q == IDX_W'(REQUEST_LENGTH - 1));
				reading_q  <= '0;
				used_q     <= '0;
			end else begin
				kind_out_q <= kind_q;
				tx_byte_q  <= 8'h00;
				tx_last_q  <= 1'b0;
				reading_q  <= reading_sat;
				used_q     <= (kind_q == KIND_ENERGY) ? used_sat : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = kind_out_q;
	assign tx_byte     = tx_byte_q;
	assign tx_last     = tx_last_q;
	assign reading     = reading_q;
	assign energy_used = $signed(used_q);

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == ST_SEND || state_q == ST_MUL))
		else $error("job taken but back end did not start it");
	a_last_req: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && tx_last) |-> (result_kind == KIND_REQ))
		else $error("last mark on a reading result");
	a_send_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEND && out_free && idx_q == IDX_W'(REQUEST_LENGTH - 1)) |=>
		(state_q == ST_IDLE && tx_last_q))
		else $error("request frame did not end on its last byte");

endmodule
`default_nettype wire

// File: sv/meter_poll_and_bcd_decode_core.sv
// top level of the meter poll and reading decode block
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------------------------
//  in        | in_valid / in_ready       | command, rx_byte, rx_last
//  out       | out_valid / out_ready     | result_kind, tx_byte, tx_last, reading, energy_used
//  config    | cfg_we (no wait)          | cfg_wdata = energy_start
//
//  a receive request whose byte ends no frame gives nothing
//  a poll request yields sixteen request bytes, one per cycle while out_ready holds, from the back end counter
//  a decoded reading leaves the queue and passes the digit, multiply, sum, diff and used steps in order
//  in_ready drops only while the four-entry job queue is full
//  reset clears phase, frame position, kept bytes, energy_start and all control state
`default_nettype none
module meter_poll_and_bcd_decode_core import mpbd_pkg::*; #(
	parameter int FRAME_CAPACITY = 24
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// input requests
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                command,
	input  wire logic [7:0]          rx_byte,
	input  wire logic                rx_last,
	// result requests
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [1:0]               result_kind,
	output logic [7:0]               tx_byte,
	output logic                     tx_last,
	output logic [READING_W-1:0]     reading,
	output logic signed [USED_W-1:0] energy_used,
	// energy_start register
	input  wire logic                cfg_we,
	input  wire logic [START_W-1:0]  cfg_wdata
);

	// front to queue
	logic push;
	job_t push_job;
	logic q_full;
	// queue to back
	logic pop;
	job_t head;
	logic q_empty;

	// front end: frame position, kept identifier and data bytes, poll rotation
	mpbd_front #(
		.FRAME_CAPACITY(FRAME_CAPACITY)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.rx_byte  (rx_byte),
		.rx_last  (rx_last),
		.q_full   (q_full),
		.push     (push),
		.job      (push_job)
	);

	// decouples request intake from the slower result stream
	mpbd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty)
	);

	// back end: request byte sequencer and bcd decode datapath
	mpbd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.empty       (q_empty),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_kind (result_kind),
		.tx_byte     (tx_byte),
		.tx_last     (tx_last),
		.reading     (reading),
		.energy_used (energy_used)
	);

endmodule
`default_nettype wire
